### sv/ltsm_pkg.sv
// Shared types, constants and the star level table for the twinkle star mask.
package ltsm_pkg;

	// Field widths of the request and result items.
	localparam int IDX_W  = 10;
	localparam int COL_W  = 8;
	localparam int RND_W  = 16;
	localparam int THR_W  = 16;
	localparam int LVL_W  = 8;
	localparam int STAR_W = 8;
	localparam int DIST_W = 7;
	localparam int POS_W  = 11;
	localparam int CFG_W  = 16;
	localparam int CFG_IDX_W = 2;

	// Default number of brightness entries.
	localparam int MAX_LEDS_DEF = 1024;

	// Remainder unit: two quotient bits are resolved per cycle.
	localparam int DIV_STEPS  = 2;
	localparam int DIV_CYCLES = IDX_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	// Queue between the front and the back.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Level written at the center of a star.
	localparam logic [LVL_W-1:0] STAR_PEAK = 8'd255;

	// Register reset values.
	localparam logic [THR_W-1:0]  RST_SPAWN_THRESHOLD = 16'd20;
	localparam logic [LVL_W-1:0]  RST_DECAY_STEP      = 8'd5;
	localparam logic [STAR_W-1:0] RST_STAR_WIDTH      = 8'd5;
	localparam logic [POS_W-1:0]  RST_STRIP_COUNT     = 11'd1024;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPAWN_THRESHOLD = 2'd0,
		REG_DECAY_STEP      = 2'd1,
		REG_STAR_WIDTH      = 2'd2,
		REG_STRIP_COUNT     = 2'd3
	} reg_idx_t;

	// Effective configuration as seen by the front and the back.
	typedef struct packed {
		logic [THR_W-1:0]  threshold;
		logic [LVL_W-1:0]  decay;
		logic [DIST_W-1:0] reach;
		logic [POS_W-1:0]  len;
	} cfg_t;

	// One classified request waiting for the back.
	typedef struct packed {
		logic [POS_W-1:0] idx;
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
		logic             spawn;
	} qentry_t;

	// Neighbour level at distance d: floor(510 / (2d + 1)).
	function automatic logic [LVL_W-1:0] star_level(input logic [DIST_W-1:0] d);
		logic [LVL_W-1:0] v;
		case (d) inside
			7'd1:          v = 8'd170;
			7'd2:          v = 8'd102;
			7'd3:          v = 8'd72;
			7'd4:          v = 8'd56;
			7'd5:          v = 8'd46;
			7'd6:          v = 8'd39;
			7'd7:          v = 8'd34;
			7'd8:          v = 8'd30;
			7'd9:          v = 8'd26;
			7'd10:         v = 8'd24;
			7'd11:         v = 8'd22;
			7'd12:         v = 8'd20;
			7'd13:         v = 8'd18;
			7'd14:         v = 8'd17;
			7'd15:         v = 8'd16;
			7'd16:         v = 8'd15;
			7'd17:         v = 8'd14;
			[7'd18:7'd19]: v = 8'd13;
			7'd20:         v = 8'd12;
			[7'd21:7'd22]: v = 8'd11;
			[7'd23:7'd25]: v = 8'd10;
			[7'd26:7'd27]: v = 8'd9;
			[7'd28:7'd31]: v = 8'd8;
			[7'd32:7'd35]: v = 8'd7;
			[7'd36:7'd42]: v = 8'd6;
			[7'd43:7'd50]: v = 8'd5;
			[7'd51:7'd63]: v = 8'd4;
			[7'd64:7'd84]: v = 8'd3;
			[7'd85:7'd127]: v = 8'd2;
			default:       v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

### sv/ltsm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ltsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the old contents when both ports hit the same entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### sv/ltsm_front.sv
// Front end: accepts requests, reduces the LED index modulo the strip length
// and classifies the request as a star spawn or a plain access.
module ltsm_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ltsm_pkg::cfg_t          cfg,
	input  logic                    clearing,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ltsm_pkg::IDX_W-1:0] led_index,
	input  logic [ltsm_pkg::COL_W-1:0] color_red,
	input  logic [ltsm_pkg::COL_W-1:0] color_green,
	input  logic [ltsm_pkg::COL_W-1:0] color_blue,
	input  logic [ltsm_pkg::RND_W-1:0] rand_value,
	output logic                    push,
	output ltsm_pkg::qentry_t       push_entry,
	input  logic                    q_full
);
	import ltsm_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t               state_q, state_d;
	logic [IDX_W-1:0]      dividend_q;
	logic [POS_W-1:0]      rem_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [COL_W-1:0]      red_q, green_q, blue_q;
	logic                  spawn_q;
	logic                  accept;
	logic [POS_W-1:0]      rem_next;

	// Two restoring remainder steps per cycle.
	always_comb begin
		logic [POS_W:0] trial;
		logic [POS_W-1:0] r;
		r = rem_q;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial = {r, dividend_q[IDX_W-1-k]};
			if (trial >= {1'b0, cfg.len}) begin
				trial = trial - {1'b0, cfg.len};
			end
			r = trial[POS_W-1:0];
		end
		rem_next = r;
	end

	// A new request is taken when idle or while the finished one leaves.
	assign in_stall = clearing || !((state_q == F_IDLE) || ((state_q == F_PUSH) && !q_full));
	assign accept   = in_valid && !in_stall;
	assign push     = (state_q == F_PUSH) && !q_full;

	assign push_entry.idx   = rem_q;
	assign push_entry.red   = red_q;
	assign push_entry.green = green_q;
	assign push_entry.blue  = blue_q;
	assign push_entry.spawn = spawn_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) state_d = F_DIV;
			end
			F_DIV: begin
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (accept) state_d = F_DIV;
				else if (push) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request registers and the remainder datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			dividend_q <= led_index;
			rem_q      <= '0;
			cnt_q      <= '0;
			red_q      <= color_red;
			green_q    <= color_green;
			blue_q     <= color_blue;
			spawn_q    <= (rand_value < cfg.threshold);
		end else if (state_q == F_DIV) begin
			rem_q      <= rem_next;
			dividend_q <= dividend_q << DIV_STEPS;
			cnt_q      <= cnt_q + 1'b1;
		end
	end

endmodule

### sv/ltsm_fifo.sv
// Short request queue between the front end and the back end.
module ltsm_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ltsm_pkg::qentry_t push_entry,
	output logic              full,
	input  logic              pop,
	output ltsm_pkg::qentry_t pop_entry,
	output logic              empty
);
	import ltsm_pkg::*;

	qentry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### sv/ltsm_back.sv
// Back end: owns the brightness store, runs the decay and star updates on it
// and produces the scaled colour.
module ltsm_back #(
	parameter int MAX_LEDS = ltsm_pkg::MAX_LEDS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ltsm_pkg::cfg_t           cfg,
	output logic                     clearing,
	input  logic                     empty,
	input  ltsm_pkg::qentry_t        pop_entry,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ltsm_pkg::COL_W-1:0] out_red,
	output logic [ltsm_pkg::COL_W-1:0] out_green,
	output logic [ltsm_pkg::COL_W-1:0] out_blue
);
	import ltsm_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	typedef enum logic [3:0] {
		B_CLEAR = 4'b0001,
		B_IDLE  = 4'b0010,
		B_RUN   = 4'b0100,
		B_FINAL = 4'b1000
	} bstate_t;

	bstate_t           state_q, state_d;
	logic [AW-1:0]     clr_q;

	// Current request.
	logic [POS_W-1:0]  idx_q;
	logic [COL_W-1:0]  red_q, green_q, blue_q;
	logic              spawn_q;
	logic [LVL_W-1:0]  mult_q, mult_d;

	// Neighbour walk.
	logic [POS_W-1:0]  left_q, left_d, right_q, right_d;
	logic [DIST_W-1:0] dist_q, dist_d;
	logic              side_q, side_d;
	logic              more_q, more_d;

	// Read in flight, resolved in the cycle after it is issued.
	logic              pend_own_s1, pend_own_d;
	logic [POS_W-1:0]  pend_pos_s1, pend_pos_d;
	logic [LVL_W-1:0]  pend_level_s1, pend_level_d;
	logic              fwd_s1, fwd_d;
	logic [LVL_W-1:0]  fwd_data_s1;

	// Store ports.
	logic              wr_en;
	logic [POS_W-1:0]  wr_pos;
	logic [AW-1:0]     wr_addr;
	logic [LVL_W-1:0]  wr_data;
	logic [POS_W-1:0]  rd_pos;
	logic [LVL_W-1:0]  rd_data;

	// Output slot.
	logic              out_valid_q;
	logic              out_free;
	logic              load_out;

	assign clearing  = (state_q == B_CLEAR);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	ltsm_ram #(
		.WIDTH(LVL_W),
		.DEPTH(MAX_LEDS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(AW'(rd_pos)),
		.rd_data(rd_data)
	);

	// Sequencer: store clear after reset; per request own read, neighbour raises, own write last.
	always_comb begin
		logic [LVL_W-1:0] cur;
		logic [POS_W-1:0] pos;
		state_d      = state_q;
		pop          = 1'b0;
		load_out     = 1'b0;
		wr_en        = 1'b0;
		wr_pos       = pend_pos_s1;
		wr_addr      = AW'(pend_pos_s1);
		wr_data      = pend_level_s1;
		rd_pos       = pend_pos_s1;
		mult_d       = mult_q;
		left_d       = left_q;
		right_d      = right_q;
		dist_d       = dist_q;
		side_d       = side_q;
		more_d       = more_q;
		pend_own_d   = pend_own_s1;
		pend_pos_d   = pend_pos_s1;
		pend_level_d = pend_level_s1;
		fwd_d        = 1'b0;
		cur          = fwd_s1 ? fwd_data_s1 : rd_data;
		pos          = '0;
		unique case (state_q)
			B_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == AW'(MAX_LEDS - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!empty) begin
					pop        = 1'b1;
					rd_pos     = pop_entry.idx;
					pend_own_d = 1'b1;
					pend_pos_d = pop_entry.idx;
					left_d     = pop_entry.idx;
					right_d    = pop_entry.idx;
					dist_d     = DIST_W'(1);
					side_d     = 1'b0;
					more_d     = pop_entry.spawn && (cfg.reach != '0);
					state_d    = B_RUN;
				end
			end
			B_RUN: begin
				// Resolve the read issued last cycle.
				if (pend_own_s1) begin
					if (spawn_q) mult_d = STAR_PEAK;
					else if (cur < cfg.decay) mult_d = '0;
					else mult_d = cur - cfg.decay;
				end else if (cur < pend_level_s1) begin
					wr_en = 1'b1;
				end
				// Issue the next neighbour read, left side first.
				if (more_q) begin
					if (!side_q) begin
						pos    = (left_q == '0) ? cfg.len - POS_W'(1) : left_q - POS_W'(1);
						left_d = pos;
					end else begin
						pos     = (right_q == cfg.len - POS_W'(1)) ? '0 : right_q + POS_W'(1);
						right_d = pos;
					end
					rd_pos       = pos;
					pend_own_d   = 1'b0;
					pend_pos_d   = pos;
					pend_level_d = star_level(dist_q);
					fwd_d        = wr_en && (wr_pos == pos);
					side_d       = !side_q;
					if (side_q) begin
						if (dist_q == cfg.reach) more_d = 1'b0;
						else dist_d = dist_q + 1'b1;
					end
				end else begin
					state_d = B_FINAL;
				end
			end
			B_FINAL: begin
				if (out_free) begin
					wr_en    = 1'b1;
					wr_addr  = AW'(idx_q);
					wr_data  = mult_q;
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_CLEAR;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Request, walk and in-flight read registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q   <= pop_entry.idx;
			red_q   <= pop_entry.red;
			green_q <= pop_entry.green;
			blue_q  <= pop_entry.blue;
			spawn_q <= pop_entry.spawn;
		end
		mult_q        <= mult_d;
		left_q        <= left_d;
		right_q       <= right_d;
		dist_q        <= dist_d;
		side_q        <= side_d;
		more_q        <= more_d;
		pend_own_s1   <= pend_own_d;
		pend_pos_s1   <= pend_pos_d;
		pend_level_s1 <= pend_level_d;
		fwd_s1        <= fwd_d;
		fwd_data_s1   <= wr_data;
	end

	// Colour scaling: component * (1 + mult), upper byte of the product.
	always_ff @(posedge clk) begin
		logic [COL_W+LVL_W:0] pr, pg, pb;
		pr = red_q   * ({1'b0, mult_q} + 9'd1);
		pg = green_q * ({1'b0, mult_q} + 9'd1);
		pb = blue_q  * ({1'b0, mult_q} + 9'd1);
		if (load_out) begin
			out_red   <= pr[2*COL_W-1:COL_W];
			out_green <= pg[2*COL_W-1:COL_W];
			out_blue  <= pb[2*COL_W-1:COL_W];
		end
	end

	// No request leaves the queue while the store is being cleared.
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> !pop)
		else $error("request taken during store clear");

	// A star center always ends at full brightness.
	a_star_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FINAL && spawn_q) |-> (mult_q == STAR_PEAK))
		else $error("star center not at peak level");

	// Writes during the walk only raise a neighbour to its level.
	a_raise_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RUN && wr_en) |-> (!pend_own_s1 && wr_data == pend_level_s1))
		else $error("unexpected store write during neighbour walk");

	// A new result appears only after a request has finished.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == B_FINAL))
		else $error("result raised outside final step");

endmodule

### sv/led_twinkle_star_mask_core.sv
// Top level of the twinkling star brightness mask: configuration and wiring.
//
// Usage: each request on the input channel (in_valid / in_stall) carries one
// LED index, an RGB colour and a random value. Every request yields exactly
// one result on the output channel (out_valid / out_stall): the colour
// scaled by the LED's updated brightness multiplier.
// The front end takes a request and reduces the index modulo the strip
// length (two remainder bits per cycle); it takes the next request only
// when idle or as the reduced one leaves. A two-entry queue feeds the back
// end, which owns the brightness store (one RAM port each for read and
// write): it reads the LED's level, on a star spawn raises star_width / 2
// neighbours on each side up to their star level, then writes the new level.
// A stalled result holds in the output register; the back end waits in its
// final step and the queue then fills, after which in_stall rises. After
// reset the store is cleared, one entry per cycle over all MAX_LEDS entries,
// with in_stall high meanwhile. Configuration writes are to apply between
// requests; the user must see to it, as the block does not enforce it.
module led_twinkle_star_mask_core #(
	parameter int MAX_LEDS = ltsm_pkg::MAX_LEDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [ltsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ltsm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ltsm_pkg::IDX_W-1:0]     led_index,
	input  logic [ltsm_pkg::COL_W-1:0]     color_red,
	input  logic [ltsm_pkg::COL_W-1:0]     color_green,
	input  logic [ltsm_pkg::COL_W-1:0]     color_blue,
	input  logic [ltsm_pkg::RND_W-1:0]     rand_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ltsm_pkg::COL_W-1:0]     out_red,
	output logic [ltsm_pkg::COL_W-1:0]     out_green,
	output logic [ltsm_pkg::COL_W-1:0]     out_blue
);
	import ltsm_pkg::*;

	logic [THR_W-1:0]  spawn_threshold_q;
	logic [LVL_W-1:0]  decay_step_q;
	logic [STAR_W-1:0] star_width_q;
	logic [POS_W-1:0]  strip_count_q;
	logic [POS_W-1:0]  len;
	cfg_t              cfg;
	logic              clearing;
	logic              push, pop, q_full, q_empty;
	qentry_t           push_entry, pop_entry;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spawn_threshold_q <= RST_SPAWN_THRESHOLD;
			decay_step_q      <= RST_DECAY_STEP;
			star_width_q      <= RST_STAR_WIDTH;
			strip_count_q     <= RST_STRIP_COUNT;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SPAWN_THRESHOLD: spawn_threshold_q <= cfg_data;
				REG_DECAY_STEP:      decay_step_q      <= cfg_data[LVL_W-1:0];
				REG_STAR_WIDTH:      star_width_q      <= cfg_data[STAR_W-1:0];
				REG_STRIP_COUNT:     strip_count_q     <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective strip length: zero acts as one, clamped to the store depth.
	always_comb begin
		if (strip_count_q == '0) len = POS_W'(1);
		else if (32'(strip_count_q) > 32'(MAX_LEDS)) len = POS_W'(MAX_LEDS);
		else len = strip_count_q;
	end

	assign cfg.threshold = spawn_threshold_q;
	assign cfg.decay     = decay_step_q;
	assign cfg.reach     = star_width_q[STAR_W-1:1];
	assign cfg.len       = len;

	ltsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.clearing   (clearing),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.led_index  (led_index),
		.color_red  (color_red),
		.color_green(color_green),
		.color_blue (color_blue),
		.rand_value (rand_value),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	ltsm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.pop_entry (pop_entry),
		.empty     (q_empty)
	);

	ltsm_back #(
		.MAX_LEDS(MAX_LEDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.clearing (clearing),
		.empty    (q_empty),
		.pop_entry(pop_entry),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_red  (out_red),
		.out_green(out_green),
		.out_blue (out_blue)
	);

endmodule
